@@ sv/load_cell_adc_reader_macros.svh @@
// assertion helpers for the load cell reader
`ifndef LOAD_CELL_ADC_READER_MACROS_SVH
`define LOAD_CELL_ADC_READER_MACROS_SVH

// same-cycle implication
`define LDR_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define LDR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/ldr_pkg.sv @@
package ldr_pkg;

  localparam int SAMPLE_BITS = 24;
  localparam int PHASE_W     = 7;
  localparam int SUM_W       = 32;
  localparam int MAG_W       = 24;
  localparam int DIV_W       = 16;
  localparam int CNT_W       = $clog2(SUM_W);
  localparam int AVG_W       = 8;
  localparam int GAIN_W      = 2;
  localparam int CFG_IDX_W   = 2;
  localparam int IN_W        = 8;
  localparam int OUT_W       = 56;

  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_PULSES    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_AVERAGE_COUNT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_REFERENCE_UNIT = 2'd2;

  localparam logic [GAIN_W-1:0] GAIN_RESET = 2'd3;
  localparam logic [AVG_W-1:0]  AVG_RESET  = 8'd1;
  localparam logic [DIV_W-1:0]  REF_RESET  = 16'd1000;

  localparam logic [SAMPLE_BITS-1:0] SIGN_MASK = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
  localparam logic [MAG_W-1:0]       MAG_MAX   = {MAG_W{1'b1}};

endpackage

@@ sv/ldr_div.sv @@
module ldr_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [ldr_pkg::SUM_W-1:0]   dividend,
  input  logic [ldr_pkg::DIV_W-1:0]   divisor,
  output logic                        busy,
  output logic [ldr_pkg::SUM_W-1:0]   quotient
);
  import ldr_pkg::*;

  logic [SUM_W-1:0] work_r;
  logic [DIV_W-1:0] rem_r;
  logic [DIV_W-1:0] dvs_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic [DIV_W:0]   rem_sh;
  logic [DIV_W:0]   rem_sub;
  logic             ge;

  // one quotient bit per cycle, msb first
  assign rem_sh  = {rem_r, work_r[SUM_W-1]};
  assign rem_sub = rem_sh - {1'b0, dvs_r};
  assign ge      = rem_sh >= {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= CNT_W'(SUM_W - 1);
    end else if (busy_r) begin
      cnt_r <= cnt_r - 1'b1;
      if (cnt_r == '0) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      work_r <= dividend;
      rem_r  <= '0;
      dvs_r  <= divisor;
    end else if (busy_r) begin
      work_r <= {work_r[SUM_W-2:0], ge};
      rem_r  <= ge ? rem_sub[DIV_W-1:0] : rem_sh[DIV_W-1:0];
    end
  end

  assign busy     = busy_r;
  assign quotient = work_r;

endmodule

@@ sv/load_cell_adc_reader.sv @@
// ordinary ticks give their result in the cycle after the request is taken
// a tick that closes an average makes two passes of the shared bit-serial
// divider, one quotient bit per cycle
// throughput: one tick per cycle otherwise, with the output register taken
// reset: rst_n synchronous active low, clears control state and offset,
// registers return to gain_pulses 3, average_count 1, reference_unit 1000
`include "load_cell_adc_reader_macros.svh"

module load_cell_adc_reader (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // data_line, tare_request
  input  logic [ldr_pkg::IN_W-1:0]        in_tdata,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // serial_clock, result_valid, raw_magnitude, weight_units, tare_done
  output logic [ldr_pkg::OUT_W-1:0]       out_tdata,
  input  logic                            cfg_we,
  input  logic [ldr_pkg::CFG_IDX_W-1:0]   cfg_addr,
  input  logic [ldr_pkg::DIV_W-1:0]       cfg_wdata
);
  import ldr_pkg::*;

  typedef enum logic [1:0] {ST_IDLE, ST_AVG, ST_MAG} state_t;

  state_t                 st_r;
  logic [GAIN_W-1:0]      gain_r;
  logic [AVG_W-1:0]       avgc_r;
  logic [DIV_W-1:0]       ref_r;
  logic [PHASE_W-1:0]     phase_r;
  logic [SAMPLE_BITS-1:0] shift_r;
  logic [SUM_W-1:0]       sum_r;
  logic [AVG_W-1:0]       cnt_r;
  logic [MAG_W-1:0]       zero_r;
  logic                   tare_r;
  logic [MAG_W-1:0]       mag_r;
  logic                   tdone_r;

  logic                   oval_r;
  logic                   oclk_r;
  logic                   ores_r;
  logic [MAG_W-1:0]       omag_r;
  logic [MAG_W-1:0]       owt_r;
  logic                   otd_r;

  logic                   accept;
  logic                   data_in;
  logic                   tare_in;
  logic [GAIN_W-1:0]      gain_eff;
  logic [PHASE_W-1:0]     end_phase;
  logic                   sample;
  logic [SAMPLE_BITS-1:0] shift_nxt;
  logic [SAMPLE_BITS-1:0] word;
  logic [SUM_W:0]         sum_ext;
  logic [SUM_W-1:0]       sum_nxt;
  logic [AVG_W-1:0]       cnt_inc;
  logic [AVG_W-1:0]       cnt_nxt;
  logic [AVG_W-1:0]       avgc_eff;
  logic [DIV_W-1:0]       ref_eff;
  logic                   at_end;
  logic                   closes;
  logic [MAG_W-1:0]       avg_sat;
  logic [MAG_W-1:0]       mag_calc;
  logic                   out_free;
  logic                   load_tick;
  logic                   load_res;
  logic                   oval_nxt;
  logic                   div_start;
  logic [SUM_W-1:0]       div_dividend;
  logic [DIV_W-1:0]       div_divisor;
  logic                   div_busy;
  logic [SUM_W-1:0]       div_q;

  assign data_in   = in_tdata[0];
  assign tare_in   = in_tdata[1];
  assign out_free  = !oval_r || out_tready;
  assign in_tready = (st_r == ST_IDLE) && out_free;
  assign accept    = in_tvalid && in_tready;

  always_comb begin
    gain_eff  = (gain_r == '0) ? GAIN_W'(1) : gain_r;
    end_phase = PHASE_W'(2 * SAMPLE_BITS) + {{(PHASE_W-GAIN_W-1){1'b0}}, gain_eff, 1'b0};
    sample    = phase_r[PHASE_W-1:1] <= (PHASE_W-1)'(SAMPLE_BITS);
    shift_nxt = {shift_r[SAMPLE_BITS-2:0], data_in};
    word      = sample ? shift_nxt : shift_r;
    sum_ext   = {1'b0, sum_r} + (SUM_W+1)'(word ^ SIGN_MASK);
    sum_nxt   = sum_ext[SUM_W] ? {SUM_W{1'b1}} : sum_ext[SUM_W-1:0];
    cnt_inc   = cnt_r + 1'b1;
    cnt_nxt   = (cnt_inc == '0) ? AVG_W'(1) : cnt_inc;
    avgc_eff  = (avgc_r == '0) ? AVG_W'(1) : avgc_r;
    ref_eff   = (ref_r == '0) ? DIV_W'(1) : ref_r;
    at_end    = (phase_r != '0) && !phase_r[0] && (phase_r >= end_phase);
    closes    = at_end && (cnt_nxt >= avgc_eff);
    avg_sat   = (div_q[SUM_W-1:MAG_W] != '0) ? MAG_MAX : div_q[MAG_W-1:0];
    if (tare_r) begin
      mag_calc = '0;
    end else if (avg_sat >= zero_r) begin
      mag_calc = avg_sat - zero_r;
    end else begin
      mag_calc = zero_r - avg_sat;
    end
  end

  // output register loads: a plain tick, or the finished result
  always_comb begin
    load_tick = accept && !closes;
    load_res  = (st_r == ST_MAG) && !div_busy && out_free;
    if (load_tick || load_res) begin
      oval_nxt = 1'b1;
    end else if (out_tready) begin
      oval_nxt = 1'b0;
    end else begin
      oval_nxt = oval_r;
    end
  end

  // shared divider: sum by count, then magnitude by reference unit
  always_comb begin
    if (st_r == ST_AVG) begin
      div_start    = !div_busy;
      div_dividend = SUM_W'(mag_calc);
      div_divisor  = ref_eff;
    end else begin
      div_start    = accept && closes;
      div_dividend = sum_nxt;
      div_divisor  = DIV_W'(cnt_nxt);
    end
  end

  ldr_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .busy     (div_busy),
    .quotient (div_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= ST_IDLE;
      gain_r  <= GAIN_RESET;
      avgc_r  <= AVG_RESET;
      ref_r   <= REF_RESET;
      phase_r <= '0;
      shift_r <= '0;
      sum_r   <= '0;
      cnt_r   <= '0;
      zero_r  <= '0;
      tare_r  <= 1'b0;
      oval_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          CFG_GAIN_PULSES:    gain_r <= cfg_wdata[GAIN_W-1:0];
          CFG_AVERAGE_COUNT:  avgc_r <= cfg_wdata[AVG_W-1:0];
          CFG_REFERENCE_UNIT: ref_r  <= cfg_wdata;
          default: ;
        endcase
      end
      oval_r <= oval_nxt;
      if (load_tick || load_res) begin
        oclk_r <= load_tick && phase_r[0];
        ores_r <= load_res;
        omag_r <= load_res ? mag_r : '0;
        owt_r  <= load_res ? div_q[MAG_W-1:0] : '0;
        otd_r  <= load_res && tdone_r;
      end
      case (st_r)
        ST_IDLE: begin
          if (accept) begin
            if (tare_in) begin
              tare_r <= 1'b1;
            end
            if (phase_r == '0) begin
              if (!data_in) begin
                shift_r <= '0;
                phase_r <= PHASE_W'(1);
              end
            end else if (phase_r[0]) begin
              phase_r <= phase_r + 1'b1;
            end else begin
              if (sample) begin
                shift_r <= shift_nxt;
              end
              if (at_end) begin
                phase_r <= '0;
                if (closes) begin
                  sum_r <= '0;
                  cnt_r <= '0;
                  st_r  <= ST_AVG;
                end else begin
                  sum_r <= sum_nxt;
                  cnt_r <= cnt_nxt;
                end
              end else begin
                phase_r <= phase_r + 1'b1;
              end
            end
          end
        end
        ST_AVG: begin
          if (!div_busy) begin
            mag_r   <= mag_calc;
            tdone_r <= tare_r;
            if (tare_r) begin
              zero_r <= avg_sat;
              tare_r <= 1'b0;
            end
            st_r <= ST_MAG;
          end
        end
        ST_MAG: begin
          if (load_res) begin
            st_r <= ST_IDLE;
          end
        end
        default: st_r <= ST_IDLE;
      endcase
    end
  end

  assign out_tvalid = oval_r;
  assign out_tdata  = {{(OUT_W-2*MAG_W-3){1'b0}}, otd_r, owt_r, omag_r, ores_r, oclk_r};

  `LDR_ASSERT_NOW(a_phase_range, 1'b1, phase_r <= PHASE_W'(2 * (SAMPLE_BITS + 3)),
    "tick phase ran past the longest pulse train")
  `LDR_ASSERT_NOW(a_tare_zero, oval_r && otd_r, omag_r == '0,
    "tare result with nonzero magnitude")
  `LDR_ASSERT_NOW(a_div_owner, div_busy, st_r == ST_AVG || st_r == ST_MAG,
    "divider running outside the division states")
  `LDR_ASSERT_NEXT(a_close_start, accept && closes, div_busy && st_r == ST_AVG,
    "closing tick did not start the average division")

endmodule
